>>> rtl/core/pcmdm_pkg.sv
// Shared constants, types and helpers for the PCM channel downmix block.
package pcmdm_pkg;

   // Field and limit sizes
   localparam int SAMPLE_W     = 32;
   localparam int CNT_W        = 5;
   localparam int MAX_CHANNELS = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int CNT_MAX      = (1 << CNT_W) - 1;
   localparam int SRC_LIMIT    = (MAX_CHANNELS < CNT_MAX) ? MAX_CHANNELS : CNT_MAX;
   localparam int DST_LIMIT0   = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;
   localparam int DST_LIMIT    = (DST_LIMIT0 < CNT_MAX) ? DST_LIMIT0 : CNT_MAX;

   // Accumulator holds up to SRC_LIMIT full-scale samples
   localparam int SUM_W  = SAMPLE_W + $clog2(SRC_LIMIT + 1);
   localparam int STEP_W = $clog2(SUM_W);

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Clamp limits as magnitudes and as output codes
   localparam logic [SAMPLE_W-1:0] W32_MAX     = 32'h7fff_ffff;
   localparam logic [SAMPLE_W-1:0] W32_MIN     = 32'h8000_0000;
   localparam logic [SAMPLE_W-1:0] W16_MAX     = 32'h0000_7fff;
   localparam logic [SAMPLE_W-1:0] W16_MIN     = 32'hffff_8000;
   localparam logic [SAMPLE_W-1:0] W16_MIN_MAG = 32'h0000_8000;

   typedef enum logic [1:0] {
      REG_FORMAT = 2'd0,
      REG_SRC_CH = 2'd1,
      REG_DST_CH = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   // Zero acts as one, large values saturate at the limit
   function automatic logic [CNT_W-1:0] eff_channels(input logic [CNT_W-1:0] n,
                                                     input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] r;
      if (n == '0) begin
         r = CNT_W'(1);
      end else if (n > lim) begin
         r = lim;
      end else begin
         r = n;
      end
      return r;
   endfunction

endpackage

>>> rtl/core/pcmdm_req_if.sv
// Request channel: one interleaved PCM sample per request.
interface pcmdm_req_if import pcmdm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       block_end;

   modport source (output valid, sample_in, block_end, input ready);
   modport sink   (input valid, sample_in, block_end, output ready);
endinterface

>>> rtl/core/pcmdm_rsp_if.sv
// Response channel: one averaged sample per output channel.
interface pcmdm_rsp_if import pcmdm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       frame_last;
   logic                       block_end_out;

   modport source (output valid, sample_out, frame_last, block_end_out, input ready);
   modport sink   (input valid, sample_out, frame_last, block_end_out, output ready);
endinterface

>>> rtl/core/pcmdm_serial_div.sv
// Bit-serial restoring divider: unsigned frame sum by channel count.
module pcmdm_serial_div import pcmdm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;
   logic              last_step;

   // One quotient bit per cycle, MSB first; dividend shifts out as quotient shifts in
   always_comb begin
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      diff      = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
      last_step = (step_ff == STEP_W'(SUM_W - 1));

      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/pcm_channel_downmix_average_top.sv
// A frame-closing request starts the divide; its first response is registered once the divider reports done.
// Requests inside a frame are taken one per cycle; a closing request holds the input
// off through the bit-serial divide and until every copy of the result has been sent.
// Copies go out one per cycle while the response side is ready.
// Reset (synchronous, active high) clears the running sum, the sample count and
// the control state, and sets the registers to format 16-bit, 2 in, 2 out.
module pcm_channel_downmix_average_top import pcmdm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   pcmdm_req_if.sink             req_chan,
   pcmdm_rsp_if.source           rsp_chan
);

   // Configuration registers
   logic             format_ff, format_in;
   logic [CNT_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0] dst_ff, dst_in;

   // Frame state and control
   state_type        state_ff, state_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             neg_ff, neg_in;
   logic             bend_ff, bend_in;
   logic [CNT_W-1:0] left_ff, left_in;

   // Response registers
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                frame_last_ff, frame_last_in;
   logic                bend_out_ff, bend_out_in;

   logic                csr_wr;
   reg_index_type       csr_idx;
   logic                req_acc;
   logic                rsp_acc;
   logic [SUM_W-1:0]    sample_ext;
   logic [SUM_W-1:0]    new_sum;
   logic [CNT_W-1:0]    new_count;
   logic [CNT_W-1:0]    eff_src;
   logic [CNT_W-1:0]    eff_dst;
   logic                frame_done;
   logic [SUM_W-1:0]    sum_mag;
   logic                div_start;
   logic                div_done;
   logic [SUM_W-1:0]    div_quot;
   logic [SUM_W-1:0]    max_mag;
   logic [SUM_W-1:0]    min_mag;
   logic [SAMPLE_W-1:0] avg;

   // Register access
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = reg_index_type'(paddr[3:2]);

   always_comb begin
      format_in = format_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FORMAT: format_in = pwdata[0];
            REG_SRC_CH: src_in    = pwdata[CNT_W-1:0];
            REG_DST_CH: dst_in    = pwdata[CNT_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FORMAT: prdata = CSR_DATA_W'(format_ff);
         REG_SRC_CH: prdata = CSR_DATA_W'(src_ff);
         REG_DST_CH: prdata = CSR_DATA_W'(dst_ff);
         default:    prdata = '0;
      endcase
   end

   // Handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign rsp_acc        = rsp_valid_ff && rsp_chan.ready;

   // Accumulate one sample; the frame closes once the count reaches the source channels
   always_comb begin
      if (format_ff) begin
         sample_ext = {{(SUM_W-SAMPLE_W){req_chan.sample_in[SAMPLE_W-1]}},
                       req_chan.sample_in};
      end else begin
         sample_ext = {{(SUM_W-16){req_chan.sample_in[15]}}, req_chan.sample_in[15:0]};
      end
      new_sum    = sum_ff + sample_ext;
      new_count  = count_ff + CNT_W'(1);
      eff_src    = eff_channels(src_ff, CNT_W'(SRC_LIMIT));
      eff_dst    = eff_channels(dst_ff, CNT_W'(DST_LIMIT));
      frame_done = (new_count >= eff_src);
      sum_mag    = new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
      div_start  = req_acc && frame_done;
   end

   pcmdm_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (eff_src),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Restore sign and clamp to the selected format
   always_comb begin
      max_mag = format_ff ? SUM_W'(W32_MAX) : SUM_W'(W16_MAX);
      min_mag = format_ff ? SUM_W'(W32_MIN) : SUM_W'(W16_MIN_MAG);
      if (neg_ff) begin
         if (div_quot > min_mag) begin
            avg = format_ff ? W32_MIN : W16_MIN;
         end else begin
            avg = ~div_quot[SAMPLE_W-1:0] + SAMPLE_W'(1);
         end
      end else begin
         if (div_quot > max_mag) begin
            avg = format_ff ? W32_MAX : W16_MAX;
         end else begin
            avg = div_quot[SAMPLE_W-1:0];
         end
      end
   end

   // Frame sequencer: gather, divide, send copies
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      bend_in       = bend_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_sample_in = out_sample_ff;
      frame_last_in = frame_last_ff;
      bend_out_in   = bend_out_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (frame_done) begin
                  sum_in   = '0;
                  count_in = '0;
                  neg_in   = new_sum[SUM_W-1];
                  bend_in  = req_chan.block_end;
                  left_in  = eff_dst;
                  state_in = S_DIV;
               end else begin
                  sum_in   = new_sum;
                  count_in = new_count;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               out_sample_in = avg;
               frame_last_in = (left_ff == CNT_W'(1));
               bend_out_in   = bend_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_acc) begin
               if (left_ff == CNT_W'(1)) begin
                  rsp_valid_in  = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  left_in       = left_ff - CNT_W'(1);
                  frame_last_in = (left_ff == CNT_W'(2));
               end
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= 1'b0;
         src_ff       <= CNT_W'(2);
         dst_ff       <= CNT_W'(2);
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      bend_ff       <= bend_in;
      out_sample_ff <= out_sample_in;
      frame_last_ff <= frame_last_in;
      bend_out_ff   <= bend_out_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_out    = out_sample_ff;
   assign rsp_chan.frame_last    = frame_last_ff;
   assign rsp_chan.block_end_out = bend_out_ff;

`ifndef ASSERT_OFF
   // Responses only come out of the send phase
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EMIT))
      else $error("response valid outside send phase");

   // The divider finishes only while a frame is being divided
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide phase");

   // The last copy of a frame ends the response burst
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && frame_last_ff) |=> (!rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("response continued past last copy");

   // A partial frame never holds as many samples as the channel limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(SRC_LIMIT))
      else $error("sample count out of range");
`endif

endmodule

>>> test/pcm_channel_downmix_average_top_tb.sv
// Testbench for the PCM channel downmix block: random and directed samples against a predictor.
module pcm_channel_downmix_average_top_tb import pcmdm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int RANDOM_ITEMS = 237;
   localparam int HOLD_CYCLES  = 400;
   localparam int DST_CAP      = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;

   // Predicts the averaged copies of each frame and checks responses in order
   class downmix_scoreboard;
      typedef struct {
         logic [SAMPLE_W-1:0] sample;
         logic                last;
         logic                block_end;
      } out_copy_type;

      bit               wide_format;
      logic [CNT_W-1:0] src_setting;
      logic [CNT_W-1:0] dst_setting;
      longint           frame_sum;
      int               frame_count;
      out_copy_type     expected_copies[$];
      int               failures;

      function new();
         wide_format = 1'b0;
         src_setting = CNT_W'(2);
         dst_setting = CNT_W'(2);
         frame_sum   = 0;
         frame_count = 0;
         failures    = 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
         end
      endfunction

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_FORMAT: begin
               wide_format = val[0];
            end
            REG_SRC_CH: begin
               src_setting = val[CNT_W-1:0];
            end
            REG_DST_CH: begin
               dst_setting = val[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Zero counts as one channel, anything past the cap is held at the cap
      function int clip_count(logic [CNT_W-1:0] n, int cap);
         if (n == '0) return 1;
         if (int'(n) > cap) return cap;
         return int'(n);
      endfunction

      function void note_request(logic [SAMPLE_W-1:0] s_in, logic be);
         longint       s;
         longint       avg;
         longint       hi;
         longint       lo;
         int           nsrc;
         int           ndst;
         out_copy_type c;
         s = wide_format ? longint'($signed(s_in)) : longint'($signed(s_in[15:0]));
         nsrc = clip_count(src_setting, MAX_CHANNELS);
         ndst = clip_count(dst_setting, DST_CAP);
         frame_sum += s;
         frame_count++;
         if (frame_count < nsrc) return;
         // Signed division truncates toward zero
         avg = frame_sum / nsrc;
         hi = wide_format ? 64'sd2147483647 : 64'sd32767;
         lo = -hi - 1;
         if (avg > hi) avg = hi;
         else if (avg < lo) avg = lo;
         frame_sum   = 0;
         frame_count = 0;
         for (int k = 0; k < ndst; k++) begin
            c.sample    = SAMPLE_W'(avg);
            c.last      = (k == ndst - 1);
            c.block_end = be;
            expected_copies.push_back(c);
         end
      endfunction

      function void check_response(logic [SAMPLE_W-1:0] s, logic last, logic be);
         out_copy_type c;
         if (expected_copies.size() == 0) begin
            flag($sformatf("unexpected response sample %h last %b end %b", s, last, be));
            return;
         end
         c = expected_copies.pop_front();
         if (c.sample !== s || c.last !== last || c.block_end !== be) begin
            flag($sformatf("expected sample %h last %b end %b, got %h %b %b",
                           c.sample, c.last, c.block_end, s, last, be));
         end
      endfunction

      function int pending();
         return expected_copies.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pcmdm_req_if req_bus ();
   pcmdm_rsp_if rsp_bus ();

   downmix_scoreboard board = new();

   int requests_seen = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit held_once     = 1'b0;

   pcm_channel_downmix_average_top uut (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle draw, switched off for a stretch of requests
   function automatic bit take_break();
      bit calm;
      calm = (requests_seen >= 150) && (requests_seen < 210);
      return !calm && ($urandom_range(0, 99) < 23);
   endfunction

   // Watch both channels
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         board.note_request(req_bus.sample_in, req_bus.block_end);
         requests_seen <= requests_seen + 1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_response(rsp_bus.sample_out, rsp_bus.frame_last, rsp_bus.block_end_out);
      end
   end

   // Response side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (!held_once && requests_seen >= 100) begin
         held_once     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !take_break();
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Write a register, then read it back
   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] want;
      want = (idx == REG_FORMAT) ? (val & 32'h1) : (val & 32'h1f);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      board.set_reg(idx, val);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         board.flag($sformatf("register %s read %h, expected %h", idx.name(), prdata, want));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request and hold it until taken
   task automatic send_sample(logic [SAMPLE_W-1:0] s, logic be);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      req_bus.block_end <= be;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   // Stop offering and let every expected copy drain out
   task automatic settle();
      req_bus.valid <= 1'b0;
      // let the monitor log the last accepted request first
      @(posedge clock);
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: r = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         1: r[15:0] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         2: r = {{24{r[7]}}, r[7:0]};
         default: begin
         end
      endcase
      return r;
   endfunction

   // Mostly legal channel counts, now and then zero or past the cap
   function automatic logic [CNT_W-1:0] pick_count();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 1) ? CNT_W'(0) : CNT_W'($urandom_range(17, 31));
      end
      return CNT_W'($urandom_range(1, 16));
   endfunction

   initial begin
      int               sent;
      int               phase;
      int               n;
      int               eff;
      logic [CNT_W-1:0] src;
      logic [CNT_W-1:0] dst;
      logic             fmt;

      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      req_bus.block_end <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 16-bit, two in, two out
      send_sample(32'h0000_7fff, 1'b0);
      send_sample(32'h0000_7fff, 1'b1);
      // block end inside a frame is dropped; upper bits ignored in 16-bit mode
      send_sample(32'h1234_8000, 1'b1);
      send_sample(32'hffff_8000, 1'b0);
      // negative averages truncate toward zero
      send_sample(32'h0000_fffd, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h0000_ffff, 1'b1);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h7fff_0001, 1'b0);
      send_sample(32'h8000_0002, 1'b1);

      // 32-bit extremes
      settle();
      write_reg(REG_FORMAT, 32'd1);
      write_reg(REG_DST_CH, 32'd3);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h7fff_ffff, 1'b1);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      send_sample(32'hffff_fffe, 1'b0);

      // Lowering the count mid-frame closes it early and the clamp bites
      settle();
      write_reg(REG_SRC_CH, 32'd3);
      write_reg(REG_DST_CH, 32'd0);
      send_sample(32'h7fff_ffff, 1'b1);
      send_sample(32'h7fff_ffff, 1'b0);
      settle();
      write_reg(REG_SRC_CH, 32'd0);
      send_sample(32'h7fff_ffff, 1'b1);

      // Same for the 16-bit floor, with the output count past the cap
      settle();
      write_reg(REG_FORMAT, 32'd0);
      write_reg(REG_SRC_CH, 32'd4);
      write_reg(REG_DST_CH, 32'd31);
      send_sample(32'h0000_8000, 1'b0);
      send_sample(32'hffff_8000, 1'b1);
      send_sample(32'h0000_8000, 1'b0);
      settle();
      write_reg(REG_SRC_CH, 32'd0);
      send_sample(32'h5555_8000, 1'b1);

      // Random phases, each with fresh settings
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         fmt = 1'($urandom_range(0, 1));
         if (phase == 0) begin
            src = CNT_W'(16);
            dst = CNT_W'(16);
         end else if (phase == 1) begin
            src = CNT_W'(1);
            dst = CNT_W'(1);
         end else begin
            src = pick_count();
            dst = pick_count();
         end
         settle();
         write_reg(REG_FORMAT, CSR_DATA_W'(fmt));
         write_reg(REG_SRC_CH, CSR_DATA_W'(src));
         write_reg(REG_DST_CH, CSR_DATA_W'(dst));
         eff = (src == '0) ? 1 : ((int'(src) > MAX_CHANNELS) ? MAX_CHANNELS : int'(src));
         // whole frames, sometimes with a partial one carried into the next phase
         n = eff * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2);
         repeat (n) begin
            send_sample(random_sample(), $urandom_range(0, 7) == 0);
         end
         sent += n;
         phase++;
      end

      settle();
      if (board.pending() != 0) begin
         board.flag($sformatf("%0d responses never arrived", board.pending()));
      end
      if (board.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/pcmdm_pkg.sv
rtl/core/pcmdm_req_if.sv
rtl/core/pcmdm_rsp_if.sv
rtl/core/pcmdm_serial_div.sv
rtl/core/pcm_channel_downmix_average_top.sv
test/pcm_channel_downmix_average_top_tb.sv
